// File: sv/slu_pkg.sv
// Shared types, codes and helper functions for the string literal unescaper.
package slu_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned KindW = 2;
	localparam int unsigned AddrW = 3;
	localparam int unsigned DataW = 32;

	// Reset values of the delimiter registers (double quote)
	localparam logic [ByteW-1:0] OpenCharRst  = 8'd34;
	localparam logic [ByteW-1:0] CloseCharRst = 8'd34;

	localparam logic [ByteW-1:0] Backslash = 8'h5C;
	localparam logic [ByteW-1:0] LetterX   = 8'h78;
	localparam logic [ByteW-1:0] PrintLo   = 8'd32;

	// Register indexes on the configuration port
	typedef enum logic [0:0] {
		REG_OPEN_CHAR  = 1'b0,
		REG_CLOSE_CHAR = 1'b1
	} reg_idx_t;

	// Scanner mode
	typedef enum logic [2:0] {
		MODE_OUT  = 3'd0,
		MODE_IN   = 3'd1,
		MODE_ESC  = 3'd2,
		MODE_HEX1 = 3'd3,
		MODE_HEX2 = 3'd4
	} mode_t;

	// Result kind
	typedef enum logic [KindW-1:0] {
		KIND_OPEN    = 2'd0,
		KIND_CONTENT = 2'd1,
		KIND_CLOSE   = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	// Outcome of one byte through the scanner
	typedef struct packed {
		logic             has_result;
		logic [ByteW-1:0] res_byte;
		kind_t            kind;
		mode_t            next_mode;
		logic [3:0]       next_nibble;
	} step_t;

	// Control letter lookup: {hit, code}
	function automatic logic [ByteW:0] ctl_lookup(input logic [ByteW-1:0] b);
		logic [ByteW:0] r;
		begin
			case (b)
				8'h61:   r = {1'b1, 8'd7};   // a
				8'h62:   r = {1'b1, 8'd8};   // b
				8'h72:   r = {1'b1, 8'd13};  // r
				8'h6E:   r = {1'b1, 8'd10};  // n
				8'h74:   r = {1'b1, 8'd9};   // t
				8'h76:   r = {1'b1, 8'd11};  // v
				8'h66:   r = {1'b1, 8'd12};  // f
				8'h30:   r = {1'b1, 8'd0};   // 0
				default: r = {1'b0, 8'd0};
			endcase
			return r;
		end
	endfunction

	// Hex digit lookup: {valid, nibble}, both letter cases
	function automatic logic [4:0] hex_lookup(input logic [ByteW-1:0] b);
		logic [4:0] r;
		logic [7:0] d;
		begin
			r = 5'd0;
			if (b >= 8'h30 && b <= 8'h39) begin
				d = b - 8'h30;
				r = {1'b1, d[3:0]};
			end else if (b >= 8'h61 && b <= 8'h66) begin
				d = b - 8'h57;
				r = {1'b1, d[3:0]};
			end else if (b >= 8'h41 && b <= 8'h46) begin
				d = b - 8'h37;
				r = {1'b1, d[3:0]};
			end
			return r;
		end
	endfunction

endpackage

// File: sv/slu_decode.sv
// Next-state and result logic of the literal scanner for one byte.
module slu_decode import slu_pkg::*; (
	input  mode_t            mode,
	input  logic [3:0]       nibble,
	input  logic [ByteW-1:0] cur_byte,
	input  logic [ByteW-1:0] open_char,
	input  logic [ByteW-1:0] close_char,
	output step_t            step
);

	logic [ByteW:0] ctl;
	logic [4:0]     hex;

	assign ctl = ctl_lookup(cur_byte);
	assign hex = hex_lookup(cur_byte);

	// Default is no result and state held; arms override
	always_comb begin
		step             = '0;
		step.res_byte    = cur_byte;
		step.kind        = KIND_ERROR;
		step.next_mode   = mode;
		step.next_nibble = nibble;
		unique case (mode)
			MODE_IN: begin
				if (cur_byte == close_char) begin
					step.has_result = 1'b1;
					step.kind       = KIND_CLOSE;
					step.next_mode  = MODE_OUT;
				end else if (cur_byte == Backslash) begin
					step.next_mode = MODE_ESC;
				end else if (cur_byte >= PrintLo && !cur_byte[7] && cur_byte != open_char) begin
					step.has_result = 1'b1;
					step.kind       = KIND_CONTENT;
				end else begin
					step.has_result = 1'b1;
					step.next_mode  = MODE_OUT;
				end
			end
			MODE_ESC: begin
				// raw meaning wins over control letters and x
				if (cur_byte == Backslash || cur_byte == open_char
						|| cur_byte == close_char) begin
					step.has_result = 1'b1;
					step.kind       = KIND_CONTENT;
					step.next_mode  = MODE_IN;
				end else if (ctl[ByteW]) begin
					step.has_result = 1'b1;
					step.res_byte   = ctl[ByteW-1:0];
					step.kind       = KIND_CONTENT;
					step.next_mode  = MODE_IN;
				end else if (cur_byte == LetterX) begin
					step.next_mode = MODE_HEX1;
				end else begin
					step.has_result = 1'b1;
					step.next_mode  = MODE_OUT;
				end
			end
			MODE_HEX1: begin
				if (hex[4]) begin
					step.next_nibble = hex[3:0];
					step.next_mode   = MODE_HEX2;
				end else begin
					step.has_result = 1'b1;
					step.next_mode  = MODE_OUT;
				end
			end
			MODE_HEX2: begin
				step.has_result = 1'b1;
				if (hex[4]) begin
					step.res_byte  = {nibble, hex[3:0]};
					step.kind      = KIND_CONTENT;
					step.next_mode = MODE_IN;
				end else begin
					step.next_mode = MODE_OUT;
				end
			end
			default: begin
				// outside, and any unused mode code
				step.next_mode = MODE_OUT;
				if (cur_byte == open_char) begin
					step.has_result = 1'b1;
					step.kind       = KIND_OPEN;
					step.next_mode  = MODE_IN;
				end
			end
		endcase
	end

endmodule

// File: sv/string_literal_unescaper_unit.sv
// Top level: byte stream decoder for delimited C-style string literals.
//
//  channel  dir  handshake           payload
//  in       in   in_valid/in_stall   in_byte[7:0]
//  out      out  out_valid/out_stall out_byte[7:0], out_kind[1:0]
//  cfg      in   APB (psel..pready)  open_char @0x0, close_char @0x4
//
// One byte per cycle sustained while the output is not stalled. A byte is
// registered on transfer, decoded against the scanner mode from the input
// register, and its result (if any) lands in the output register. The output
// register frees up on the same edge it transfers, so a stalled output holds
// the input stage and raises in_stall only while both are occupied. Reset puts
// the scanner outside a literal and both delimiters to double quote.
module string_literal_unescaper_unit import slu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [ByteW-1:0] in_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [ByteW-1:0] out_byte,
	output logic [KindW-1:0] out_kind,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready
);

	logic [ByteW-1:0] open_char_q;
	logic [ByteW-1:0] close_char_q;
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	mode_t            mode_q;
	logic [3:0]       nibble_q;
	logic             out_valid_q;
	logic [ByteW-1:0] out_byte_q;
	kind_t            out_kind_q;
	step_t            step;
	logic             out_free;
	logic             advance;
	logic             in_xfer;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	// Configuration registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_char_q  <= OpenCharRst;
			close_char_q <= CloseCharRst;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_OPEN_CHAR:  open_char_q  <= pwdata[ByteW-1:0];
				REG_CLOSE_CHAR: close_char_q <= pwdata[ByteW-1:0];
				default:        open_char_q  <= open_char_q;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_OPEN_CHAR:  prdata = {{(DataW-ByteW){1'b0}}, open_char_q};
			REG_CLOSE_CHAR: prdata = {{(DataW-ByteW){1'b0}}, close_char_q};
			default:        prdata = '0;
		endcase
	end

	// Flow control: the stage-1 byte moves on when the output slot is free
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= in_byte;
		end
	end

	// Scanner decode
	slu_decode u_decode (
		.mode       (mode_q),
		.nibble     (nibble_q),
		.cur_byte   (byte_s1),
		.open_char  (open_char_q),
		.close_char (close_char_q),
		.step       (step)
	);

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_OUT;
			nibble_q <= 4'd0;
		end else if (advance) begin
			mode_q   <= step.next_mode;
			nibble_q <= step.next_nibble;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && step.has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.has_result) begin
			out_byte_q <= step.res_byte;
			out_kind_q <= step.kind;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_kind  = out_kind_q;

endmodule

// File: tb/tb_string_literal_unescaper_unit.sv
// Self-checking testbench for the string literal unescaper: byte stream in, decoded bytes out.
module tb_string_literal_unescaper_unit;
	import slu_pkg::*;

	// Control letters and the codes they stand for after a backslash
	localparam logic [ByteW-1:0] CtlLetters [8] = '{8'h61, 8'h62, 8'h72, 8'h6E,
		8'h74, 8'h76, 8'h66, 8'h30};
	localparam logic [ByteW-1:0] CtlCodes [8] = '{8'd7, 8'd8, 8'd13, 8'd10,
		8'd9, 8'd11, 8'd12, 8'd0};
	localparam int PhaseItems = 240;

	// Tracks scanner state and delimiters, and queues the decoded bytes due out
	class unescape_tracker;
		typedef struct packed {
			logic [ByteW-1:0] b;
			kind_t            k;
		} decoded_t;

		logic [ByteW-1:0] open_ch;
		logic [ByteW-1:0] close_ch;
		mode_t            mode;
		logic [3:0]       hi_nib;
		decoded_t         due_bytes[$];
		int               mismatches;

		function new();
			open_ch    = OpenCharRst;
			close_ch   = CloseCharRst;
			mode       = MODE_OUT;
			hi_nib     = 4'd0;
			mismatches = 0;
		endfunction

		function void set_delim(reg_idx_t idx, logic [ByteW-1:0] v);
			if (idx == REG_OPEN_CHAR) open_ch = v;
			else close_ch = v;
		endfunction

		// {valid, nibble} for a hex digit of either case
		function logic [4:0] hex_digit(logic [ByteW-1:0] b);
			logic [ByteW-1:0] d;
			d = 8'd0;
			if (b >= 8'h30 && b <= 8'h39) d = b - 8'h30;
			else if (b >= 8'h61 && b <= 8'h66) d = b - 8'h61 + 8'd10;
			else if (b >= 8'h41 && b <= 8'h46) d = b - 8'h41 + 8'd10;
			else return 5'd0;
			return {1'b1, d[3:0]};
		endfunction

		function void emit(logic [ByteW-1:0] b, kind_t k);
			decoded_t e;
			e.b = b;
			e.k = k;
			due_bytes.push_back(e);
		endfunction

		function void bad_byte(logic [ByteW-1:0] b);
			mode = MODE_OUT;
			emit(b, KIND_ERROR);
		endfunction

		// Advance the scanner by one accepted input byte
		function void take_byte(logic [ByteW-1:0] b);
			logic [4:0] h;
			bit         hit;
			hit = 1'b0;
			case (mode)
				MODE_IN: begin
					if (b == close_ch) begin
						mode = MODE_OUT;
						emit(b, KIND_CLOSE);
					end else if (b == Backslash) begin
						mode = MODE_ESC;
					end else if (!b[7] && b >= PrintLo && b != open_ch) begin
						emit(b, KIND_CONTENT);
					end else begin
						bad_byte(b);
					end
				end
				MODE_ESC: begin
					// raw meaning wins over control letter or x
					if (b == Backslash || b == open_ch || b == close_ch) begin
						mode = MODE_IN;
						emit(b, KIND_CONTENT);
					end else begin
						for (int i = 0; i < 8; i++) begin
							if (!hit && CtlLetters[i] == b) begin
								hit  = 1'b1;
								mode = MODE_IN;
								emit(CtlCodes[i], KIND_CONTENT);
							end
						end
						if (!hit) begin
							if (b == LetterX) mode = MODE_HEX1;
							else bad_byte(b);
						end
					end
				end
				MODE_HEX1: begin
					h = hex_digit(b);
					if (!h[4]) begin
						bad_byte(b);
					end else begin
						hi_nib = h[3:0];
						mode   = MODE_HEX2;
					end
				end
				MODE_HEX2: begin
					h = hex_digit(b);
					if (!h[4]) begin
						bad_byte(b);
					end else begin
						mode = MODE_IN;
						emit({hi_nib, h[3:0]}, KIND_CONTENT);
					end
				end
				default: begin
					mode = MODE_OUT;
					if (b == open_ch) begin
						mode = MODE_IN;
						emit(b, KIND_OPEN);
					end
				end
			endcase
		endfunction

		// Compare one output transfer with the oldest pending decode
		function void match_output(logic [ByteW-1:0] b, logic [KindW-1:0] k);
			decoded_t e;
			if (due_bytes.size() == 0) begin
				$error("unexpected output: out_byte %02h out_kind %0d", b, k);
				mismatches++;
				return;
			end
			e = due_bytes.pop_front();
			if (b !== e.b) begin
				$error("out_byte: expected %02h, got %02h", e.b, b);
				mismatches++;
			end
			if (k !== e.k) begin
				$error("out_kind: expected %0d, got %0d", e.k, k);
				mismatches++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [ByteW-1:0] in_byte;
	logic             out_valid;
	logic             out_stall;
	logic [ByteW-1:0] out_byte;
	logic [KindW-1:0] out_kind;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;

	bit  calm;
	bit  hold_req;
	int  sent;

	unescape_tracker tracker = new();

	string_literal_unescaper_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.out_kind (out_kind),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watch both channels; a transfer is valid high with stall low at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) tracker.match_output(out_byte, out_kind);
			if (in_valid && !in_stall) tracker.take_byte(in_byte);
		end
	end

	// Output side: random stall, plus a long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 120;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 31);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Offer one byte, with random idle cycles ahead of it, until it transfers
	task automatic push_byte(input logic [ByteW-1:0] b);
		while (!calm && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Stop offering and wait until every decode has come out, then for the pipe.
	// The first edge lets the monitor record the last accepted byte.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.due_bytes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [ByteW-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(DataW-ByteW){1'b0}}, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_delim(idx, v);
	endtask

	function automatic logic [ByteW-1:0] hex_char();
		int v;
		v = $urandom_range(15);
		if (v < 10) return 8'h30 + 8'(v);
		return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(v - 10);
	endfunction

	// One literal: mostly well-formed pieces, some noise and broken escapes
	task automatic send_literal();
		int               pieces;
		int               r;
		logic [ByteW-1:0] o;
		logic [ByteW-1:0] c;
		o = tracker.open_ch;
		c = tracker.close_ch;
		if ($urandom_range(99) < 20) push_byte(8'($urandom_range(255)));
		push_byte(o);
		pieces = $urandom_range(12);
		repeat (pieces) begin
			r = $urandom_range(99);
			if (r < 45) begin
				push_byte(8'($urandom_range(127, 32)));
			end else if (r < 60) begin
				push_byte(Backslash);
				push_byte(CtlLetters[$urandom_range(7)]);
			end else if (r < 70) begin
				push_byte(Backslash);
				case ($urandom_range(2))
					0:       push_byte(Backslash);
					1:       push_byte(o);
					default: push_byte(c);
				endcase
			end else if (r < 85) begin
				push_byte(Backslash);
				push_byte(LetterX);
				push_byte(hex_char());
				push_byte(hex_char());
			end else if (r < 92) begin
				push_byte(Backslash);
				if ($urandom_range(1)) push_byte(LetterX);
				push_byte(8'($urandom_range(255)));
			end else begin
				push_byte(8'($urandom_range(255)));
			end
		end
		if ($urandom_range(99) < 92) push_byte(c);
	endtask

	initial begin : main_seq
		logic [ByteW-1:0] dir[$];
		logic [ByteW-1:0] opens[8];
		logic [ByteW-1:0] closes[8];
		in_valid = 1'b0;
		in_byte  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		calm     = 1'b0;
		hold_req = 1'b0;
		sent     = 0;
		arst_n   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset delimiters: pass-through, escapes, hex, and the error paths
		dir = '{8'h22, 8'h41, 8'h20, 8'h7F, Backslash, Backslash, Backslash, 8'h22,
			Backslash, 8'h6E, Backslash, LetterX, 8'h34, 8'h46, 8'h22,
			8'h22, 8'hFF, 8'h22, Backslash, 8'h71, 8'h22, Backslash, LetterX, 8'h67,
			8'h22, 8'h1F};
		foreach (dir[i]) push_byte(dir[i]);
		settle();

		// Distinct delimiters: unescaped opener inside is an error
		reg_write(REG_OPEN_CHAR, 8'h28);
		reg_write(REG_CLOSE_CHAR, 8'h29);
		dir = '{8'h28, 8'h61, 8'h28, 8'h28, Backslash, 8'h28, 8'h29};
		foreach (dir[i]) push_byte(dir[i]);
		settle();

		// Delimiters that are also escape letters: raw meaning wins
		reg_write(REG_OPEN_CHAR, 8'h6E);
		reg_write(REG_CLOSE_CHAR, LetterX);
		dir = '{8'h6E, Backslash, 8'h6E, Backslash, LetterX, LetterX};
		foreach (dir[i]) push_byte(dir[i]);
		settle();

		// Random literals under several delimiter settings
		opens  = '{8'd34, 8'd0, 8'd255, 8'h27, 8'h3C, 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255))};
		closes = '{8'd34, 8'd255, 8'd0, 8'h27, 8'h3E, 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255))};
		for (int p = 0; p < 8; p++) begin
			reg_write(REG_OPEN_CHAR, opens[p]);
			reg_write(REG_CLOSE_CHAR, closes[p]);
			calm = (p == 2);
			sent = 0;
			while (sent < PhaseItems) begin
				if (p == 4 && sent >= 50 && sent < 60) hold_req = 1'b1;
				send_literal();
			end
			settle();
		end
		calm = 1'b0;

		if (tracker.mismatches == 0 && tracker.due_bytes.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
